[hdl/mep_pkg.sv]
package mep_pkg;

   localparam int unsigned RES_W  = 30;
   localparam int unsigned BASE_W = 63;
   localparam int unsigned EXP_W  = 64;
   localparam int unsigned PROD_W = 62;
   localparam int unsigned CNT_W  = 3;

   localparam logic [RES_W-1:0] PRIME = 30'd1000000007;
   localparam logic [RES_W-1:0] ORDER = 30'd1000000006;

   // Barrett constants floor(2^60 / m) for both moduli
   localparam logic [60:0]      TWO_60 = 61'd1 << 60;
   localparam logic [30:0]      MU     = 31'(TWO_60 / 61'(PRIME));
   localparam logic [30:0]      MU_ORD = 31'(TWO_60 / 61'(ORDER));

   localparam logic [31:0]      PRIME_X1 = 32'(PRIME);
   localparam logic [31:0]      PRIME_X2 = 32'(PRIME) << 1;
   localparam logic [31:0]      PRIME_X3 = 32'(PRIME) * 32'd3;
   localparam logic [31:0]      ORDER_X1 = 32'(ORDER);
   localparam logic [31:0]      ORDER_X2 = 32'(ORDER) << 1;

   // operand reduction: two digits of the base, then two of the exponent
   localparam logic [CNT_W-1:0] RED_LAST = 3'd3;
   localparam logic [CNT_W-1:0] RED_DONE = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIGIT,
      ST_FIXUP,
      ST_LOOP,
      ST_MUL_AB,
      ST_MUL_Q,
      ST_MUL_QP,
      ST_MUL_SUB,
      ST_FINISH
   } mep_state_type;

   typedef enum logic [2:0] {
      MOP_NONE,
      MOP_DIG,
      MOP_AB,
      MOP_Q,
      MOP_QP,
      MOP_SUB
   } mep_mop_type;

   // SEL_SQR also targets b for the base digits; SEL_EXP targets e, mod ORDER
   typedef enum logic [1:0] {
      SEL_ACC,
      SEL_SQR,
      SEL_EXP
   } mep_sel_type;

   typedef struct packed {
      logic        load;
      logic        fixup;
      mep_mop_type mop;
      mep_sel_type sel;
      logic        shift_e;
      logic        out_load;
   } mep_cmd_type;

   typedef struct packed {
      logic e_zero;
      logic e_lsb;
   } mep_status_type;

endpackage

[hdl/modular_exponentiation_prime.sv]
// Computes req_base ** req_exponent mod 1000000007 and returns one response per
// request. The base is reduced mod the prime and the signed exponent mod
// (prime - 1), negative exponents following Fermat, so an exponent that
// reduces to zero gives 1 for any base. One request is in work at a time: the
// operands are reduced two 30-bit digits each through the single 31x31
// multiplier with Barrett reduction (four digit steps), one fix-up step, then
// up to 30 exponent bits, each a loop check plus one or two modular products,
// then a load of the response register. The next request is taken while a
// finished response waits.
module modular_exponentiation_prime (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mep_pkg::BASE_W-1:0]            req_base,
   input  logic signed [mep_pkg::EXP_W-1:0]      req_exponent,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mep_pkg::RES_W-1:0]             rsp_power_result
);

   mep_pkg::mep_cmd_type    cmd;
   mep_pkg::mep_status_type status;

   mep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mep_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_base         (req_base),
      .req_exponent     (req_exponent),
      .rsp_power_result (rsp_power_result)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_power_result < mep_pkg::PRIME))
      else $error("response not below the prime");

endmodule

[hdl/mep_datapath.sv]
module mep_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  mep_pkg::mep_cmd_type          cmd,
   output mep_pkg::mep_status_type       status,
   input  logic [mep_pkg::BASE_W-1:0]    req_base,
   input  logic signed [mep_pkg::EXP_W-1:0] req_exponent,
   output logic [mep_pkg::RES_W-1:0]     rsp_power_result
);

   logic [59:0]                base_hold_ff, base_hold_in;
   logic [59:0]                mag_hold_ff, mag_hold_in;
   logic                       neg_ff, neg_in;
   logic [mep_pkg::RES_W-1:0]  b_ff, b_in;
   logic [mep_pkg::RES_W-1:0]  e_ff, e_in;
   logic [mep_pkg::RES_W-1:0]  acc_ff, acc_in;
   logic [59:0]                x_ff, x_in;
   logic [mep_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [mep_pkg::RES_W-1:0]  result_ff, result_in;

   logic [30:0]                op_a, op_b;
   logic [31:0]                r_raw, r_m1, r_m2, r_fix;
   logic [31:0]                mod_x1, mod_x2;
   logic [30:0]                mod_mu;
   logic [mep_pkg::RES_W-1:0]  mod_val;
   logic                       exp_sel;
   logic [mep_pkg::EXP_W-1:0]  mag_load;

   // magnitude of the exponent; the most negative value gives 2^63 as unsigned
   assign mag_load = req_exponent[mep_pkg::EXP_W-1]
                   ? (~req_exponent) + 64'd1 : req_exponent;

   // exponent digits reduce mod ORDER, everything else mod PRIME
   assign exp_sel = (cmd.sel == mep_pkg::SEL_EXP);
   assign mod_val = exp_sel ? mep_pkg::ORDER    : mep_pkg::PRIME;
   assign mod_mu  = exp_sel ? mep_pkg::MU_ORD   : mep_pkg::MU;
   assign mod_x1  = exp_sel ? mep_pkg::ORDER_X1 : mep_pkg::PRIME_X1;
   assign mod_x2  = exp_sel ? mep_pkg::ORDER_X2 : mep_pkg::PRIME_X2;

   // Barrett remainder is below 3m, so at most two corrections
   assign r_raw = x_ff[31:0] - prod_ff[31:0];
   assign r_m1  = r_raw - mod_x1;
   assign r_m2  = r_raw - mod_x2;

   always_comb begin
      priority if (r_raw >= mod_x2) begin
         r_fix = r_m2;
      end else if (r_raw >= mod_x1) begin
         r_fix = r_m1;
      end else begin
         r_fix = r_raw;
      end
   end

   always_comb begin
      unique case (cmd.mop)
         mep_pkg::MOP_AB: begin
            op_a = {1'b0, (cmd.sel == mep_pkg::SEL_ACC) ? acc_ff : b_ff};
            op_b = {1'b0, b_ff};
         end
         mep_pkg::MOP_Q: begin
            op_a = prod_ff[59:29];
            op_b = mod_mu;
         end
         mep_pkg::MOP_QP: begin
            op_a = prod_ff[61:31];
            op_b = {1'b0, mod_val};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      base_hold_in = base_hold_ff;
      mag_hold_in  = mag_hold_ff;
      neg_in       = neg_ff;
      b_in         = b_ff;
      e_in         = e_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      prod_in      = prod_ff;
      result_in    = result_ff;

      // top bits are already below either modulus; the rest goes in 30-bit digits
      if (cmd.load) begin
         base_hold_in = req_base[59:0];
         mag_hold_in  = mag_load[59:0];
         neg_in       = req_exponent[mep_pkg::EXP_W-1];
         b_in         = {{(mep_pkg::RES_W-3){1'b0}}, req_base[mep_pkg::BASE_W-1:60]};
         e_in         = {{(mep_pkg::RES_W-4){1'b0}}, mag_load[mep_pkg::EXP_W-1:60]};
         acc_in       = 30'd1;
      end

      if (cmd.mop == mep_pkg::MOP_DIG) begin
         if (exp_sel) begin
            prod_in     = {2'b00, e_ff, mag_hold_ff[59:30]};
            mag_hold_in = mag_hold_ff << 30;
         end else begin
            prod_in      = {2'b00, b_ff, base_hold_ff[59:30]};
            base_hold_in = base_hold_ff << 30;
         end
      end

      if (cmd.fixup) begin
         if (neg_ff && (e_ff != '0)) begin
            e_in = mep_pkg::ORDER - e_ff;
         end
      end

      if ((cmd.mop == mep_pkg::MOP_AB) || (cmd.mop == mep_pkg::MOP_Q)
          || (cmd.mop == mep_pkg::MOP_QP)) begin
         prod_in = mep_pkg::PROD_W'(op_a) * mep_pkg::PROD_W'(op_b);
      end

      if (cmd.mop == mep_pkg::MOP_Q) begin
         x_in = prod_ff[59:0];
      end

      if (cmd.mop == mep_pkg::MOP_SUB) begin
         if (cmd.sel == mep_pkg::SEL_ACC) begin
            acc_in = r_fix[mep_pkg::RES_W-1:0];
         end else if (cmd.sel == mep_pkg::SEL_EXP) begin
            e_in = r_fix[mep_pkg::RES_W-1:0];
         end else begin
            b_in = r_fix[mep_pkg::RES_W-1:0];
         end
      end

      if (cmd.shift_e) begin
         e_in = e_ff >> 1;
      end

      if (cmd.out_load) begin
         result_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      base_hold_ff <= base_hold_in;
      mag_hold_ff  <= mag_hold_in;
      neg_ff       <= neg_in;
      b_ff         <= b_in;
      e_ff         <= e_in;
      acc_ff       <= acc_in;
      x_ff         <= x_in;
      prod_ff      <= prod_in;
      result_ff    <= result_in;
   end

   assign status.e_zero    = (e_ff == '0);
   assign status.e_lsb     = e_ff[0];
   assign rsp_power_result = result_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.fixup |=> (e_ff < mep_pkg::ORDER))
      else $error("reduced exponent out of range");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.mop == mep_pkg::MOP_SUB) |-> (r_raw < mep_pkg::PRIME_X3))
      else $error("Barrett remainder exceeds 3P");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.mop == mep_pkg::MOP_SUB) |=> (acc_ff < mep_pkg::PRIME && b_ff < mep_pkg::PRIME))
      else $error("modular product not fully reduced");

endmodule

[hdl/mep_ctrl.sv]
module mep_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mep_pkg::mep_cmd_type    cmd,
   input  mep_pkg::mep_status_type status
);

   mep_pkg::mep_state_type   state_ff, state_in;
   mep_pkg::mep_sel_type     sel_ff, sel_in;
   logic [mep_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mep_pkg::ST_IDLE;
         sel_ff       <= mep_pkg::SEL_ACC;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      cmd          = '0;
      cmd.mop      = mep_pkg::MOP_NONE;
      cmd.sel      = sel_ff;

      unique case (state_ff)
         mep_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               sel_in   = mep_pkg::SEL_SQR;
               state_in = mep_pkg::ST_DIGIT;
            end
         end
         mep_pkg::ST_DIGIT: begin
            cmd.mop  = mep_pkg::MOP_DIG;
            state_in = mep_pkg::ST_MUL_Q;
         end
         mep_pkg::ST_FIXUP: begin
            cmd.fixup = 1'b1;
            state_in  = mep_pkg::ST_LOOP;
         end
         mep_pkg::ST_LOOP: begin
            if (status.e_zero) begin
               state_in = mep_pkg::ST_FINISH;
            end else begin
               sel_in   = status.e_lsb ? mep_pkg::SEL_ACC : mep_pkg::SEL_SQR;
               state_in = mep_pkg::ST_MUL_AB;
            end
         end
         mep_pkg::ST_MUL_AB: begin
            cmd.mop  = mep_pkg::MOP_AB;
            state_in = mep_pkg::ST_MUL_Q;
         end
         mep_pkg::ST_MUL_Q: begin
            cmd.mop  = mep_pkg::MOP_Q;
            state_in = mep_pkg::ST_MUL_QP;
         end
         mep_pkg::ST_MUL_QP: begin
            cmd.mop  = mep_pkg::MOP_QP;
            state_in = mep_pkg::ST_MUL_SUB;
         end
         mep_pkg::ST_MUL_SUB: begin
            cmd.mop = mep_pkg::MOP_SUB;
            if (cnt_ff != mep_pkg::RED_DONE) begin
               // operand digits: base low digit next, then both exponent digits
               cnt_in = cnt_ff + 1'b1;
               sel_in = (cnt_ff == '0) ? mep_pkg::SEL_SQR : mep_pkg::SEL_EXP;
               if (cnt_ff == mep_pkg::RED_LAST) begin
                  state_in = mep_pkg::ST_FIXUP;
               end else begin
                  state_in = mep_pkg::ST_DIGIT;
               end
            end else if (sel_ff == mep_pkg::SEL_ACC) begin
               // multiply into acc is always followed by the square of b
               sel_in   = mep_pkg::SEL_SQR;
               state_in = mep_pkg::ST_MUL_AB;
            end else begin
               cmd.shift_e = 1'b1;
               state_in    = mep_pkg::ST_LOOP;
            end
         end
         mep_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mep_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mep_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mep_pkg::ST_FINISH && rsp_valid_ff && rsp_stall)
      |=> (state_ff == mep_pkg::ST_FINISH && rsp_valid_ff))
      else $error("result overwrote a pending response");

endmodule

[tb/tb_top.sv]
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [63:0] EXP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] EXP_MIN = 64'sh8000_0000_0000_0000;
   localparam logic [62:0]        BASE_MAX = {63{1'b1}};

   class power_scoreboard;
      logic [mep_pkg::RES_W-1:0] expected_q[$];
      int failures = 0;

      // right-to-left square-and-multiply with the exponent folded mod (p - 1)
      function logic [mep_pkg::RES_W-1:0] fermat_power(logic [mep_pkg::BASE_W-1:0] base,
                                                      logic signed [mep_pkg::EXP_W-1:0] exponent);
         longint unsigned p, ord, raw, mag, b, e, acc;
         p   = 64'(mep_pkg::PRIME);
         ord = 64'(mep_pkg::ORDER);
         raw = exponent;
         b   = {1'b0, base} % p;
         if (raw[63]) begin
            mag = ~raw + 64'd1;
            e   = mag % ord;
            if (e != 0) e = ord - e;
         end else begin
            e = raw % ord;
         end
         acc = 1;
         while (e != 0) begin
            if (e[0]) acc = (acc * b) % p;
            b = (b * b) % p;
            e = e >> 1;
         end
         return acc[mep_pkg::RES_W-1:0];
      endfunction

      function void note_request(logic [mep_pkg::BASE_W-1:0] base,
                                 logic signed [mep_pkg::EXP_W-1:0] exponent);
         expected_q.push_back(fermat_power(base, exponent));
      endfunction

      function void check_response(logic [mep_pkg::RES_W-1:0] actual);
         logic [mep_pkg::RES_W-1:0] want;
         if (expected_q.size() == 0) begin
            $error("power_result: no request pending, actual %0d", actual);
            failures++;
         end else begin
            want = expected_q.pop_front();
            if (actual !== want) begin
               $error("power_result mismatch: expected %0d, actual %0d", want, actual);
               failures++;
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [mep_pkg::BASE_W-1:0]          req_base;
   logic signed [mep_pkg::EXP_W-1:0]    req_exponent;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [mep_pkg::RES_W-1:0]           rsp_power_result;

   power_scoreboard sb = new();
   int sent = 0;
   int taken = 0;

   modular_exponentiation_prime dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_base         (req_base),
      .req_exponent     (req_exponent),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_power_result (rsp_power_result)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_request(logic [mep_pkg::BASE_W-1:0] base,
                               logic signed [mep_pkg::EXP_W-1:0] exponent);
      int gap;
      if ((sent / 128) % 4 == 3) gap = 0;
      else gap = $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_base     <= base;
      req_exponent <= exponent;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_request(base, exponent);
      sent++;
   endtask

   task automatic random_request();
      logic [63:0]        wide;
      logic [63:0]        ord;
      logic [62:0]        base;
      logic signed [63:0] exponent;
      int                 kind;
      ord      = 64'(mep_pkg::ORDER);
      kind     = $urandom_range(0, 9);
      wide     = {$urandom, $urandom};
      base     = wide[62:0];
      exponent = {$urandom, $urandom};
      case (kind)
         4: begin
            base     = 63'($urandom_range(0, 1000000006));
            exponent = 64'(signed'($urandom_range(0, 80))) - 64'sd40;
         end
         5: begin
            // exponents at or next to a multiple of the group order
            exponent = 64'(ord * 64'($urandom)) + 64'(signed'($urandom_range(0, 4))) - 64'sd2;
            if ($urandom_range(0, 1) == 1) exponent = -exponent;
         end
         6: base = 63'(64'(mep_pkg::PRIME) * 64'($urandom)) + 63'($urandom_range(0, 2));
         7: begin
            case ($urandom_range(0, 2))
               0: base = '0;
               1: base = 63'd1;
               default: base = 63'(mep_pkg::ORDER);
            endcase
         end
         8: begin
            if ($urandom_range(0, 1) == 1) exponent = EXP_MIN + 64'($urandom_range(0, 16));
            else exponent = EXP_MAX - 64'($urandom_range(0, 16));
         end
         9: exponent = 64'(signed'($urandom));
         default: ;
      endcase
      send_request(base, exponent);
   endtask

   // response side: random back-pressure, one long hold-off to fill the block
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken == 250) hold = 3000;
         else if ((taken / 96) % 4 == 1) hold = 0;
         else hold = $urandom_range(0, 19);
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_power_result);
         taken++;
      end
   end

   initial begin
      logic signed [63:0] ord;
      logic [62:0]        prime;
      ord          = 64'(mep_pkg::ORDER);
      prime        = 63'(mep_pkg::PRIME);
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_base     = '0;
      req_exponent = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request('0, 64'sd0);
      send_request('0, 64'sd5);
      send_request('0, -ord);
      send_request(prime, 64'sd0);
      send_request(prime, 64'sd3);
      send_request(prime * 63'd2, -64'sd7);
      send_request(BASE_MAX, EXP_MAX);
      send_request(BASE_MAX, EXP_MIN);
      send_request(63'd1, EXP_MIN);
      send_request(63'd7, EXP_MIN + 64'sd1);
      send_request(63'd2, -64'sd1);
      send_request(63'd5, 64'sd1);
      send_request(prime - 63'd1, 64'sd2);
      send_request(prime - 63'd1, ord - 64'sd1);
      send_request(63'd3, ord);
      send_request(63'd3, -ord + 64'sd1);
      send_request(prime + 63'd2, 64'sd10);
      send_request(63'd12345, -(ord * 64'sd3) - 64'sd2);
      send_request(63'd2, 64'sd1 <<< 62);
      send_request(63'd1 << 62, 64'sd1 <<< 62);
      send_request(BASE_MAX, 64'sd0);

      repeat (1750) random_request();
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (sb.failures == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
